// ----- design/cesu_pkg.sv -----
`default_nettype none
package cesu_pkg;

  // Field widths
  localparam int POS_W   = 20;
  localparam int EN_W    = 24;
  localparam int TOT_W   = 36;
  localparam int WSUM_W  = 56;
  localparam int HITS_W  = 13;
  localparam int PROD_W  = POS_W + EN_W + 1;

  // Opcodes
  localparam logic [1:0] OP_HIT       = 2'd0;
  localparam logic [1:0] OP_HIT_CLOSE = 2'd1;
  localparam logic [1:0] OP_CLOSE     = 2'd2;

  // Record kinds
  localparam logic [2:0] REC_TOTAL = 3'd0;
  localparam logic [2:0] REC_BOXHI = 3'd1;
  localparam logic [2:0] REC_BOXLO = 3'd2;
  localparam logic [2:0] REC_PEAK  = 3'd3;
  localparam logic [2:0] REC_WEAK  = 3'd4;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [EN_W-1:0]         hit_energy;
  } in_item_t;

  typedef struct packed {
    logic [2:0]              record_kind;
    logic [TOT_W-1:0]        energy_value;
    logic signed [POS_W-1:0] out_x;
    logic signed [POS_W-1:0] out_y;
    logic signed [POS_W-1:0] out_z;
    logic [HITS_W-1:0]       hits_seen;
    logic                    zero_energy;
    logic                    hits_dropped;
    logic                    last_record;
  } out_item_t;

  // Running event statistics, index 0 = x, 1 = y, 2 = z
  typedef struct packed {
    logic [HITS_W-1:0]           hits_seen;
    logic                        overflow;
    logic [TOT_W-1:0]            energy_total;
    logic [2:0][WSUM_W-1:0]      wsum;
    logic [2:0][POS_W-1:0]       box_hi;
    logic [2:0][POS_W-1:0]       box_lo;
    logic [EN_W-1:0]             peak_e;
    logic [2:0][POS_W-1:0]       peak_pos;
    logic [EN_W-1:0]             weak_e;
    logic [2:0][POS_W-1:0]       weak_pos;
  } stats_t;

endpackage
`default_nettype wire

// ----- design/cesu_accum.sv -----
`default_nettype none
module cesu_accum #(
  parameter int MAX_HITS = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              clear,
  input  wire cesu_pkg::in_item_t hit,
  output logic                   busy,
  output cesu_pkg::stats_t       stats
);

  localparam int CW = $clog2(MAX_HITS + 1);
  localparam int PW = cesu_pkg::POS_W;
  localparam int EW = cesu_pkg::EN_W;
  localparam int SW = cesu_pkg::WSUM_W;
  localparam int TW = cesu_pkg::TOT_W;
  localparam int MW = cesu_pkg::PROD_W;

  logic [CW-1:0]          cnt_r;
  logic                   ovf_r;
  logic [TW-1:0]          tot_r;
  logic [2:0][SW-1:0]     wsum_r;
  logic [2:0][PW-1:0]     bhi_r, blo_r, ppos_r, wpos_r;
  logic [EW-1:0]          pe_r, we_r;
  logic [2:0][PW-1:0]     p_r;
  logic [EW-1:0]          e_r;
  logic signed [MW-1:0]   prod_r;
  logic [1:0]             ph_r;
  logic                   busy_r;

  logic [2:0][PW-1:0]     p_in;
  logic                   full;
  logic [TW:0]            tot_sum;
  logic [PW-1:0]          mul_a;
  logic signed [MW-1:0]   mul_out;
  logic [SW-1:0]          acc_old;
  logic signed [SW:0]     acc_sum;
  logic [SW-1:0]          acc_new;

  assign p_in = {hit.pos_z, hit.pos_y, hit.pos_x};
  assign full = (cnt_r == CW'(MAX_HITS));
  assign tot_sum = {1'b0, tot_r} + (TW+1)'(hit.hit_energy);

  // Shared multiplier operand by phase
  always_comb begin
    unique case (ph_r)
      2'd0:    mul_a = p_r[0];
      2'd1:    mul_a = p_r[1];
      default: mul_a = p_r[2];
    endcase
  end
  assign mul_out = MW'($signed(mul_a) * $signed({1'b0, e_r}));

  // Saturating accumulate of the previous product
  always_comb begin
    unique case (ph_r)
      2'd1:    acc_old = wsum_r[0];
      2'd2:    acc_old = wsum_r[1];
      default: acc_old = wsum_r[2];
    endcase
    acc_sum = $signed({acc_old[SW-1], acc_old}) + (SW+1)'(prod_r);
    if (acc_sum[SW] != acc_sum[SW-1])
      acc_new = acc_sum[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    else
      acc_new = acc_sum[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      tot_r  <= '0;
      wsum_r <= '0;
      bhi_r  <= '0;
      blo_r  <= '0;
      ppos_r <= '0;
      wpos_r <= '0;
      pe_r   <= '0;
      we_r   <= '0;
      busy_r <= 1'b0;
      ph_r   <= '0;
    end else if (start) begin
      if (full) begin
        ovf_r <= 1'b1;
      end else begin
        cnt_r  <= cnt_r + 1'b1;
        tot_r  <= tot_sum[TW] ? {TW{1'b1}} : tot_sum[TW-1:0];
        p_r    <= p_in;
        e_r    <= hit.hit_energy;
        ph_r   <= '0;
        busy_r <= 1'b1;
        if (cnt_r == '0) begin
          bhi_r  <= p_in;
          blo_r  <= p_in;
          ppos_r <= p_in;
          wpos_r <= p_in;
          pe_r   <= hit.hit_energy;
          we_r   <= hit.hit_energy;
        end else begin
          for (int i = 0; i < 3; i++) begin
            if ($signed(p_in[i]) > $signed(bhi_r[i])) bhi_r[i] <= p_in[i];
            if ($signed(p_in[i]) < $signed(blo_r[i])) blo_r[i] <= p_in[i];
          end
          if (hit.hit_energy > pe_r) begin
            pe_r   <= hit.hit_energy;
            ppos_r <= p_in;
          end
          if (hit.hit_energy < we_r) begin
            we_r   <= hit.hit_energy;
            wpos_r <= p_in;
          end
        end
      end
    end else if (busy_r) begin
      // phase n multiplies axis n and accumulates axis n-1
      prod_r <= mul_out;
      unique case (ph_r)
        2'd1:    wsum_r[0] <= acc_new;
        2'd2:    wsum_r[1] <= acc_new;
        2'd3:    wsum_r[2] <= acc_new;
        default: ;
      endcase
      ph_r <= ph_r + 1'b1;
      if (ph_r == 2'd3) busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  always_comb begin
    stats.hits_seen    = cesu_pkg::HITS_W'(cnt_r);
    stats.overflow     = ovf_r;
    stats.energy_total = tot_r;
    stats.wsum         = wsum_r;
    stats.box_hi       = bhi_r;
    stats.box_lo       = blo_r;
    stats.peak_e       = pe_r;
    stats.peak_pos     = ppos_r;
    stats.weak_e       = we_r;
    stats.weak_pos     = wpos_r;
  end

endmodule
`default_nettype wire

// ----- design/cesu_div.sv -----
`default_nettype none
module cesu_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [cesu_pkg::WSUM_W-1:0]   sum,
  input  wire logic [cesu_pkg::TOT_W-1:0]    total,
  output logic                               done,
  output logic [cesu_pkg::POS_W-1:0]         quot
);

  localparam int SW = cesu_pkg::WSUM_W;
  localparam int TW = cesu_pkg::TOT_W;
  localparam int PW = cesu_pkg::POS_W;
  localparam int NW = $clog2(SW + 1);

  logic [TW-1:0] rem_r, den_r;
  logic [SW-1:0] quo_r;
  logic          neg_r, busy_r, done_r;
  logic [NW-1:0] cnt_r;

  logic [SW-1:0] mag;
  logic [TW:0]   shifted;
  logic          fits;
  logic          big;

  assign mag     = sum[SW-1] ? (~sum + 1'b1) : sum;
  assign shifted = {rem_r, quo_r[SW-1]};
  assign fits    = shifted >= {1'b0, den_r};

  // Restoring divide, one quotient bit a cycle; rounding added up front
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      rem_r  <= '0;
      quo_r  <= mag + SW'(total >> 1);
      den_r  <= total;
      neg_r  <= sum[SW-1];
      cnt_r  <= NW'(SW);
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      rem_r  <= fits ? TW'(shifted - {1'b0, den_r}) : shifted[TW-1:0];
      quo_r  <= {quo_r[SW-2:0], fits};
      cnt_r  <= cnt_r - 1'b1;
      if (cnt_r == NW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // Clamp to the signed position range
  assign big = |quo_r[SW-1:PW-1];
  always_comb begin
    if (neg_r)
      quot = big ? {1'b1, {(PW-1){1'b0}}} : (~quo_r[PW-1:0] + 1'b1);
    else
      quot = big ? {1'b0, {(PW-1){1'b1}}} : quo_r[PW-1:0];
  end

  assign done = done_r;

endmodule
`default_nettype wire

// ----- design/calorimeter_event_statistics_unit.sv -----
// Hit item: accepted while idle, then run through the phases of the shared
// multiplier and accumulator before a return to idle; no new item is taken
// until then (a hit dropped at capacity skips the phases).
// Event close: three 56-step divisions on one divider (skipped at zero total
// energy), then five records, one per cycle unstalled.
// Synchronous active-low reset clears all event state and the output valid flag.
`default_nettype none
module calorimeter_event_statistics_unit #(
  parameter int MAX_HITS = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire cesu_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output cesu_pkg::out_item_t      out_data
);

  localparam int PW = cesu_pkg::POS_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_HIT, ST_CLOSE, ST_DIV_START, ST_DIV_WAIT, ST_EMIT
  } state_t;

  state_t              state_r;
  logic                close_r;
  logic [1:0]          axis_r;
  logic [2:0]          kind_r;
  logic [2:0][PW-1:0]  bary_r;
  logic                out_valid_r;
  cesu_pkg::out_item_t out_data_r;

  logic                acc_start, acc_clear, acc_busy;
  cesu_pkg::stats_t    stats;
  logic                div_start, div_done;
  logic [cesu_pkg::WSUM_W-1:0] div_sum;
  logic [PW-1:0]       div_quot;
  logic                accept, load, zero_e;
  cesu_pkg::out_item_t rec;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign acc_start = accept && (in_data.op == cesu_pkg::OP_HIT ||
                                in_data.op == cesu_pkg::OP_HIT_CLOSE);
  assign load      = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
  assign acc_clear = load && (kind_r == cesu_pkg::REC_WEAK);
  assign div_start = (state_r == ST_DIV_START);
  assign zero_e    = (stats.energy_total == '0);

  always_comb begin
    unique case (axis_r)
      2'd0:    div_sum = stats.wsum[0];
      2'd1:    div_sum = stats.wsum[1];
      default: div_sum = stats.wsum[2];
    endcase
  end

  cesu_accum #(.MAX_HITS(MAX_HITS)) u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .start (acc_start),
    .clear (acc_clear),
    .hit   (in_data),
    .busy  (acc_busy),
    .stats (stats)
  );

  cesu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .sum   (div_sum),
    .total (stats.energy_total),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Record builder
  always_comb begin
    rec.record_kind  = kind_r;
    rec.hits_seen    = stats.hits_seen;
    rec.zero_energy  = zero_e;
    rec.hits_dropped = stats.overflow;
    rec.last_record  = (kind_r == cesu_pkg::REC_WEAK);
    unique case (kind_r)
      cesu_pkg::REC_TOTAL: begin
        rec.energy_value = stats.energy_total;
        {rec.out_z, rec.out_y, rec.out_x} = bary_r;
      end
      cesu_pkg::REC_BOXHI: begin
        rec.energy_value = '0;
        {rec.out_z, rec.out_y, rec.out_x} = stats.box_hi;
      end
      cesu_pkg::REC_BOXLO: begin
        rec.energy_value = '0;
        {rec.out_z, rec.out_y, rec.out_x} = stats.box_lo;
      end
      cesu_pkg::REC_PEAK: begin
        rec.energy_value = cesu_pkg::TOT_W'(stats.peak_e);
        {rec.out_z, rec.out_y, rec.out_x} = stats.peak_pos;
      end
      default: begin
        rec.energy_value = cesu_pkg::TOT_W'(stats.weak_e);
        {rec.out_z, rec.out_y, rec.out_x} = stats.weak_pos;
      end
    endcase
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      close_r     <= 1'b0;
      axis_r      <= '0;
      kind_r      <= cesu_pkg::REC_TOTAL;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            close_r <= (in_data.op == cesu_pkg::OP_HIT_CLOSE);
            if (acc_start) state_r <= ST_HIT;
            else if (in_data.op == cesu_pkg::OP_CLOSE) state_r <= ST_CLOSE;
          end
        end
        ST_HIT: begin
          if (!acc_busy) state_r <= close_r ? ST_CLOSE : ST_IDLE;
        end
        ST_CLOSE: begin
          axis_r <= '0;
          kind_r <= cesu_pkg::REC_TOTAL;
          if (zero_e) begin
            bary_r  <= '0;
            state_r <= ST_EMIT;
          end else begin
            state_r <= ST_DIV_START;
          end
        end
        ST_DIV_START: state_r <= ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (div_done) begin
            bary_r[axis_r] <= div_quot;
            if (axis_r == 2'd2) begin
              state_r <= ST_EMIT;
            end else begin
              axis_r  <= axis_r + 1'b1;
              state_r <= ST_DIV_START;
            end
          end
        end
        ST_EMIT: begin
          if (load) begin
            out_data_r  <= rec;
            out_valid_r <= 1'b1;
            if (kind_r == cesu_pkg::REC_WEAK) state_r <= ST_IDLE;
            else kind_r <= kind_r + 1'b1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Only the weakest-hit record closes an event
  a_last_rec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_record == (out_data.record_kind == cesu_pkg::REC_WEAK)))
    else $error("last_record on wrong record");

  // Zero total energy forces a zero barycentre
  a_zero_bary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.record_kind == cesu_pkg::REC_TOTAL && out_data.zero_energy
    |-> out_data.out_x == '0 && out_data.out_y == '0 && out_data.out_z == '0)
    else $error("barycentre not zero at zero energy");

  // Zero-energy flag agrees with the total
  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.record_kind == cesu_pkg::REC_TOTAL
    |-> out_data.zero_energy == (out_data.energy_value == '0))
    else $error("zero_energy flag mismatch");

  // Box records carry no energy
  a_box_energy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.record_kind == cesu_pkg::REC_BOXHI ||
                  out_data.record_kind == cesu_pkg::REC_BOXLO)
    |-> out_data.energy_value == '0)
    else $error("box record with energy");

  // No divider start while a hit is still accumulating
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !acc_busy)
    else $error("divider started during accumulation");

endmodule
`default_nettype wire

// ----- dv/calorimeter_event_statistics_unit_tb.sv -----
`default_nettype none
module calorimeter_event_statistics_unit_tb;

  localparam int MAX_HITS = 4096;
  localparam int WDOG_LIMIT = 20000;
  localparam int HOLD_START = 20;
  localparam int HOLD_LEN = 400;
  localparam logic [1:0] OP_NONE = 2'd3;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  cesu_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  cesu_pkg::out_item_t out_data;

  calorimeter_event_statistics_unit #(.MAX_HITS(MAX_HITS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Event accumulator mirror
  int unsigned ev_hits;
  logic [cesu_pkg::TOT_W-1:0] ev_total;
  longint ev_wsum [3];
  longint ev_box_hi [3];
  longint ev_box_lo [3];
  logic [cesu_pkg::EN_W-1:0] ev_peak_e;
  longint ev_peak_pos [3];
  logic [cesu_pkg::EN_W-1:0] ev_weak_e;
  longint ev_weak_pos [3];
  bit ev_ovf;

  cesu_pkg::in_item_t pending_items [$];
  cesu_pkg::out_item_t expected_records [$];
  int errors;
  bit stim_done;
  bit quiet_tail;
  int wdog;

  task automatic add_pending(cesu_pkg::in_item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic add_expected(cesu_pkg::out_item_t r);
    expected_records.insert(expected_records.size(), r);
  endtask

  task automatic clear_event();
    ev_hits = 0;
    ev_total = '0;
    ev_peak_e = '0;
    ev_weak_e = '0;
    ev_ovf = 1'b0;
    for (int i = 0; i < 3; i++) begin
      ev_wsum[i] = 0;
      ev_box_hi[i] = 0;
      ev_box_lo[i] = 0;
      ev_peak_pos[i] = 0;
      ev_weak_pos[i] = 0;
    end
  endtask

  // Rounded division, halves away from zero, clamped to position range
  function automatic longint barycentre(longint s, longint t);
    longint mag;
    longint q;
    mag = (s < 0) ? -s : s;
    q = (mag + t / 2) / t;
    if (s < 0) q = -q;
    if (q > 524287) q = 524287;
    if (q < -524288) q = -524288;
    return q;
  endfunction

  function automatic cesu_pkg::out_item_t make_record(logic [2:0] kind,
                                                      logic [cesu_pkg::TOT_W-1:0] e,
                                                      longint px, longint py, longint pz);
    cesu_pkg::out_item_t r;
    r.record_kind = kind;
    r.energy_value = e;
    r.out_x = px[cesu_pkg::POS_W-1:0];
    r.out_y = py[cesu_pkg::POS_W-1:0];
    r.out_z = pz[cesu_pkg::POS_W-1:0];
    r.hits_seen = ev_hits[cesu_pkg::HITS_W-1:0];
    r.zero_energy = (ev_total == 0);
    r.hits_dropped = ev_ovf;
    r.last_record = (kind == cesu_pkg::REC_WEAK);
    return r;
  endfunction

  task automatic accumulate_item(cesu_pkg::in_item_t it);
    longint p [3];
    longint e;
    longint b [3];
    logic [cesu_pkg::TOT_W:0] tsum;
    if (it.op == OP_NONE) return;
    if (it.op == cesu_pkg::OP_HIT || it.op == cesu_pkg::OP_HIT_CLOSE) begin
      p[0] = it.pos_x;
      p[1] = it.pos_y;
      p[2] = it.pos_z;
      e = it.hit_energy;
      if (ev_hits >= MAX_HITS) ev_ovf = 1'b1;
      else begin
        tsum = ev_total + it.hit_energy;
        ev_total = tsum[cesu_pkg::TOT_W] ? '1 : tsum[cesu_pkg::TOT_W-1:0];
        for (int i = 0; i < 3; i++) ev_wsum[i] += p[i] * e;
        if (ev_hits == 0) begin
          for (int i = 0; i < 3; i++) begin
            ev_box_hi[i] = p[i];
            ev_box_lo[i] = p[i];
            ev_peak_pos[i] = p[i];
            ev_weak_pos[i] = p[i];
          end
          ev_peak_e = it.hit_energy;
          ev_weak_e = it.hit_energy;
        end else begin
          for (int i = 0; i < 3; i++) begin
            if (p[i] > ev_box_hi[i]) ev_box_hi[i] = p[i];
            if (p[i] < ev_box_lo[i]) ev_box_lo[i] = p[i];
          end
          if (it.hit_energy > ev_peak_e) begin
            ev_peak_e = it.hit_energy;
            for (int i = 0; i < 3; i++) ev_peak_pos[i] = p[i];
          end
          if (it.hit_energy < ev_weak_e) begin
            ev_weak_e = it.hit_energy;
            for (int i = 0; i < 3; i++) ev_weak_pos[i] = p[i];
          end
        end
        ev_hits++;
      end
      if (it.op == cesu_pkg::OP_HIT) return;
    end
    for (int i = 0; i < 3; i++)
      b[i] = (ev_total == 0) ? 0 : barycentre(ev_wsum[i], longint'(ev_total));
    add_expected(make_record(cesu_pkg::REC_TOTAL, ev_total, b[0], b[1], b[2]));
    add_expected(make_record(cesu_pkg::REC_BOXHI, '0,
      ev_box_hi[0], ev_box_hi[1], ev_box_hi[2]));
    add_expected(make_record(cesu_pkg::REC_BOXLO, '0,
      ev_box_lo[0], ev_box_lo[1], ev_box_lo[2]));
    add_expected(make_record(cesu_pkg::REC_PEAK, cesu_pkg::TOT_W'(ev_peak_e),
      ev_peak_pos[0], ev_peak_pos[1], ev_peak_pos[2]));
    add_expected(make_record(cesu_pkg::REC_WEAK, cesu_pkg::TOT_W'(ev_weak_e),
      ev_weak_pos[0], ev_weak_pos[1], ev_weak_pos[2]));
    clear_event();
  endtask

  function automatic cesu_pkg::in_item_t hit_item(logic [1:0] op,
                                                  logic [cesu_pkg::POS_W-1:0] x,
                                                  logic [cesu_pkg::POS_W-1:0] y,
                                                  logic [cesu_pkg::POS_W-1:0] z,
                                                  logic [cesu_pkg::EN_W-1:0] e);
    cesu_pkg::in_item_t it;
    it.op = op;
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    it.hit_energy = e;
    return it;
  endfunction

  function automatic logic [cesu_pkg::POS_W-1:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return 20'h7FFFF;
      1: return 20'h80000;
      2: return cesu_pkg::POS_W'($urandom_range(0, 31) - 16);
      default: return cesu_pkg::POS_W'($urandom());
    endcase
  endfunction

  function automatic logic [cesu_pkg::EN_W-1:0] rand_energy();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return '1;
      2: return cesu_pkg::EN_W'($urandom_range(0, 3));
      default: return cesu_pkg::EN_W'($urandom());
    endcase
  endfunction

  function automatic cesu_pkg::in_item_t rand_hit(logic [1:0] op);
    return hit_item(op, rand_pos(), rand_pos(), rand_pos(), rand_energy());
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stimulus
  initial begin
    int n;
    int len;
    errors = 0;
    stim_done = 1'b0;
    quiet_tail = 1'b0;
    clear_event();
    // Directed: empty close, zero energy event, extremes, ties, unused opcode
    add_pending(hit_item(cesu_pkg::OP_CLOSE, '0, '0, '0, '0));
    add_pending(hit_item(cesu_pkg::OP_HIT, 20'h7FFFF, 20'h80000, 20'h00001, '0));
    add_pending(hit_item(cesu_pkg::OP_HIT_CLOSE, 20'h80000, 20'h7FFFF, 20'hFFFFF, '0));
    add_pending(hit_item(cesu_pkg::OP_HIT, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF, '1));
    add_pending(hit_item(cesu_pkg::OP_HIT, 20'h80000, 20'h80000, 20'h80000, '1));
    add_pending(hit_item(cesu_pkg::OP_HIT, 20'h00010, 20'hFFFF0, 20'h0, 24'h1));
    add_pending(hit_item(cesu_pkg::OP_HIT_CLOSE, 20'h00020, 20'h00001, 20'h3, 24'h1));
    add_pending(hit_item(OP_NONE, 20'h12345, 20'h54321, 20'hABCDE, 24'h777));
    add_pending(hit_item(cesu_pkg::OP_HIT, 20'h00001, 20'h0, 20'h0, 24'h3));
    add_pending(hit_item(cesu_pkg::OP_HIT, 20'h00002, 20'h0, 20'h0, 24'h1));
    add_pending(hit_item(cesu_pkg::OP_CLOSE, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF, '1));
    add_pending(hit_item(cesu_pkg::OP_HIT_CLOSE, 20'hFFFFF, 20'h00003, 20'h0, 24'h2));
    add_pending(hit_item(cesu_pkg::OP_HIT, 20'h55555, 20'hAAAAA, 20'h55555, 24'h555555));
    add_pending(hit_item(cesu_pkg::OP_HIT_CLOSE, 20'hAAAAA, 20'h55555, 20'hAAAAA,
      24'hAAAAAA));
    // Random events, mostly short, a closing op with or without a hit
    n = 0;
    while (n < 420) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      for (int i = 0; i < len; i++) begin
        add_pending(rand_hit(($urandom_range(0, 19) == 0) ? OP_NONE : cesu_pkg::OP_HIT));
        n++;
      end
      add_pending(rand_hit($urandom_range(0, 1) ? cesu_pkg::OP_HIT_CLOSE : cesu_pkg::OP_CLOSE));
      n++;
    end
    for (int i = 0; i < 20; i++)
      add_pending(rand_hit(i % 3 == 2 ? cesu_pkg::OP_HIT_CLOSE : cesu_pkg::OP_HIT));
    add_pending(rand_hit(cesu_pkg::OP_CLOSE));

    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_items.size() < 60);
    quiet_tail = 1'b1;
    wait (pending_items.size() == 0 && !in_valid);
    stim_done = 1'b1;
  end

  // Driver
  int in_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      in_gap <= 0;
    end else if (in_valid && in_stall) begin
      // hold the offered item
    end else begin
      if (in_valid) void'(pending_items.pop_front());
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 15) == 0) begin
        in_gap <= $urandom_range(0, 11);
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pending_items[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Prediction on every accepted input item
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) accumulate_item(in_data);
  end

  // Receiver stall, with one long hold-off early in the run
  int out_gap;
  int hold_left;
  int rx_cycles;
  bit hold_done;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b1;
      out_gap <= 0;
      hold_left <= 0;
      rx_cycles <= 0;
      hold_done <= 1'b0;
    end else begin
      rx_cycles <= rx_cycles + 1;
      if (!hold_done && rx_cycles == HOLD_START) begin
        hold_left <= HOLD_LEN;
        hold_done <= 1'b1;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= (hold_left > 1);
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= (out_gap > 1);
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(1, 12);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    cesu_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_records.size() == 0) begin
        errors++;
        $display("%0t: unexpected record: expected none actual %p", $time, out_data);
      end else begin
        want = expected_records.pop_front();
        if (out_data !== want) begin
          errors++;
          $display("%0t: record differs: expected %p actual %p", $time, want, out_data);
        end
      end
    end
  end

  // Watchdog and end of run
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("calorimeter_event_statistics_unit: mismatch");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    wait (expected_records.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_records.size() == 0) begin
      $display("calorimeter_event_statistics_unit: match");
    end else begin
      $display("calorimeter_event_statistics_unit: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire
